### src/swe_pkg.sv
package swe_pkg;

    // Field and register widths
    localparam int TIME_W     = 48;
    localparam int PROG_W     = 25;
    localparam int OUT_W      = 63;
    localparam int WIN_W      = 32;
    localparam int PI_W       = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Product of (1 - progress) and elapsed time
    localparam int PROD_W = TIME_W + PROG_W;

    // Ring depth default
    localparam int RING_DEPTH_DEF = 64;

    // Constants
    localparam logic [PROG_W-1:0] ONE_Q24      = 25'h100_0000;
    localparam logic [WIN_W-1:0]  WINDOW_RESET = 32'd60000;
    localparam logic [PI_W-1:0]   PI_RESET     = 8'd1;
    localparam logic [PI_W-1:0]   SSP_MAX      = 8'hFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PUBLISH = 1'b1;

    // Commands
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Status of the serial multiply/divide unit
    typedef struct packed {
        logic busy;
        logic done;
    } swe_md_status_t;

endpackage

### src/swe_ram.sv
module swe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/swe_muldiv.sv
module swe_muldiv
    import swe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PROG_W-1:0] a,
    input  logic [TIME_W-1:0] dt,
    input  logic [PROG_W-1:0] dp,
    output swe_md_status_t    status,
    output logic [OUT_W-1:0]  result
);

    localparam logic [1:0] MD_IDLE = 2'd0;
    localparam logic [1:0] MD_MUL  = 2'd1;
    localparam logic [1:0] MD_DIV  = 2'd2;

    localparam int CNT_W = $clog2(PROD_W);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(PROG_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

    logic [1:0]        phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    // hi:lo is the product during multiply, then numerator/quotient during divide
    logic [TIME_W-1:0] hi_reg, hi_next;
    logic [PROG_W-1:0] lo_reg, lo_next;
    logic [PROG_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0] dt_reg, dt_next;
    logic [PROG_W-1:0] dp_reg, dp_next;

    logic [TIME_W:0]   mul_sum;
    logic [PROG_W:0]   trial;
    logic              qbit;
    logic [PROD_W-1:0] num;

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        rem_next   = rem_reg;
        dt_next    = dt_reg;
        dp_next    = dp_reg;
        num        = {hi_reg, lo_reg};

        // Shift-add step: multiplier bits leave lo from the bottom
        mul_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, dt_reg} : '0);

        // Restoring division step, one quotient bit per cycle
        trial = {rem_reg, num[PROD_W-1]};
        qbit  = (trial >= {1'b0, dp_reg});

        case (phase_reg)
            MD_IDLE: begin
                if (start) begin
                    hi_next    = '0;
                    lo_next    = a;
                    dt_next    = dt;
                    dp_next    = dp;
                    rem_next   = '0;
                    cnt_next   = MUL_LAST;
                    phase_next = MD_MUL;
                end
            end
            MD_MUL: begin
                hi_next = mul_sum[TIME_W:1];
                lo_next = {mul_sum[0], lo_reg[PROG_W-1:1]};
                if (cnt_reg == '0) begin
                    cnt_next   = DIV_LAST;
                    phase_next = MD_DIV;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            MD_DIV: begin
                rem_next = qbit ? PROG_W'(trial - {1'b0, dp_reg}) : trial[PROG_W-1:0];
                {hi_next, lo_next} = {num[PROD_W-2:0], qbit};
                if (cnt_reg == '0) begin
                    done_next  = 1'b1;
                    phase_next = MD_IDLE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default: begin
                phase_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        rem_reg <= rem_next;
        dt_reg  <= dt_next;
        dp_reg  <= dp_next;
    end

    // Quotient bits above the output range force saturation
    always_comb begin
        if (|num[PROD_W-1:OUT_W]) begin
            result = '1;
        end else begin
            result = num[OUT_W-1:0];
        end
    end

    assign status.busy = (phase_reg != MD_IDLE);
    assign status.done = done_reg;

endmodule

### src/sliding_window_eta_estimator_top.sv
// Channel   Direction  Ports
// s_        in         s_valid s_ready s_cmd s_sample_time_ms s_progress
// m_        out        m_valid m_ready m_remaining_ms
// cfg_      in         cfg_valid cfg_ready cfg_index cfg_data
//
// One transaction at a time; a clear command is handled in ST_IDLE. A sample is stored,
// then trimmed through ST_TRIM_RD and ST_TRIM_CMP for each entry, then checked in ST_PUB;
// if an estimate is due, ST_PUB_CHK runs its checks and, when it goes ahead, the serial
// unit multiplies, divides and finishes, and ST_OUT passes the result to the output.
// Synchronous active-low reset; no clearing pass, the ring is tracked by
// oldest slot and held count. A result waiting on m_ready stalls the next one.
module sliding_window_eta_estimator_top
    import swe_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  logic [TIME_W-1:0]     s_sample_time_ms,
    input  logic [PROG_W-1:0]     s_progress,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [OUT_W-1:0]      m_remaining_ms,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int HW = $clog2(RING_DEPTH + 1);
    localparam int EW = TIME_W + PROG_W;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_TRIM_RD  = 3'd1;
    localparam logic [2:0] ST_TRIM_CMP = 3'd2;
    localparam logic [2:0] ST_PUB      = 3'd3;
    localparam logic [2:0] ST_PUB_CHK  = 3'd4;
    localparam logic [2:0] ST_MULDIV   = 3'd5;
    localparam logic [2:0] ST_OUT      = 3'd6;

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] x);
        logic [AW-1:0] r;
        if (x == AW'(RING_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = x + 1'b1;
        end
        return r;
    endfunction

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     oldest_reg, oldest_next;
    logic [HW-1:0]     held_reg, held_next;
    logic [PI_W-1:0]   ssp_reg, ssp_next;
    logic [WIN_W-1:0]  window_reg;
    logic [PI_W-1:0]   pi_reg;
    logic [TIME_W-1:0] t_reg, t_next;
    logic [PROG_W-1:0] p_reg, p_next;
    logic              m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [EW-1:0]     ram_rdata;
    logic [TIME_W-1:0] rd_time;
    logic [PROG_W-1:0] rd_prog;

    logic              md_start;
    logic [PROG_W-1:0] md_a, md_dp;
    logic [TIME_W-1:0] md_dt;
    swe_md_status_t    md_stat;
    logic [OUT_W-1:0]  md_result;

    logic              s_acc;
    logic              hist_clr;
    logic [AW-1:0]     o1;
    logic [HW-1:0]     h1;
    logic [PI_W-1:0]   ssp1;
    logic [AW:0]       slot_sum;
    logic [TIME_W:0]   trim_lhs;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign rd_time   = ram_rdata[EW-1:PROG_W];
    assign rd_prog   = ram_rdata[PROG_W-1:0];

    // Sample store
    swe_ram #(
        .WIDTH(EW),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({s_sample_time_ms, s_progress}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Serial estimate unit
    swe_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md_start),
        .a       (md_a),
        .dt      (md_dt),
        .dp      (md_dp),
        .status  (md_stat),
        .result  (md_result)
    );

    // Sample intake: history reset, full-ring drop, slot of the new entry; trim and estimate operands
    always_comb begin
        hist_clr = (held_reg != '0) &&
                   ((s_sample_time_ms < t_reg) || (s_progress < p_reg));
        o1   = hist_clr ? '0 : oldest_reg;
        h1   = hist_clr ? '0 : held_reg;
        ssp1 = hist_clr ? '0 : ssp_reg;
        if (h1 >= HW'(RING_DEPTH)) begin
            o1 = slot_inc(o1);
            h1 = h1 - 1'b1;
        end
        slot_sum  = {1'b0, o1} + {1'b0, h1[AW-1:0]};
        ram_waddr = (slot_sum >= (AW+1)'(RING_DEPTH)) ?
                    AW'(slot_sum - (AW+1)'(RING_DEPTH)) : slot_sum[AW-1:0];
        trim_lhs  = {1'b0, rd_time} + {{(TIME_W+1-WIN_W){1'b0}}, window_reg};
        md_a      = ONE_Q24 - p_reg;
        md_dt     = t_reg - rd_time;
        md_dp     = p_reg - rd_prog;
    end

    // Control sequencer
    always_comb begin
        state_next   = state_reg;
        oldest_next  = oldest_reg;
        held_next    = held_reg;
        ssp_next     = ssp_reg;
        t_next       = t_reg;
        p_next       = p_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_raddr    = oldest_reg;
        md_start     = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_cmd == CMD_CLEAR) begin
                        oldest_next = '0;
                        held_next   = '0;
                        ssp_next    = '0;
                    end else begin
                        ram_we      = 1'b1;
                        oldest_next = o1;
                        held_next   = h1 + 1'b1;
                        ssp_next    = (ssp1 != SSP_MAX) ? ssp1 + 1'b1 : ssp1;
                        t_next      = s_sample_time_ms;
                        p_next      = s_progress;
                        state_next  = ST_TRIM_RD;
                    end
                end
            end
            ST_TRIM_RD: begin
                ram_raddr = slot_inc(oldest_reg);
                if (held_reg > HW'(2)) begin
                    state_next = ST_TRIM_CMP;
                end else begin
                    state_next = ST_PUB;
                end
            end
            ST_TRIM_CMP: begin
                // Entry after the oldest is still at or before the cutoff
                if (trim_lhs <= {1'b0, t_reg}) begin
                    oldest_next = slot_inc(oldest_reg);
                    held_next   = held_reg - 1'b1;
                    state_next  = ST_TRIM_RD;
                end else begin
                    state_next = ST_PUB;
                end
            end
            ST_PUB: begin
                ram_raddr = oldest_reg;
                if ((ssp_reg < pi_reg) || (held_reg < HW'(2))) begin
                    state_next = ST_IDLE;
                end else begin
                    ssp_next   = '0;
                    state_next = ST_PUB_CHK;
                end
            end
            ST_PUB_CHK: begin
                if ((p_reg < rd_prog) || (t_reg < rd_time) ||
                    (md_dp == '0) || (md_dt == '0) || (p_reg > ONE_Q24)) begin
                    state_next = ST_IDLE;
                end else begin
                    md_start   = 1'b1;
                    state_next = ST_MULDIV;
                end
            end
            ST_MULDIV: begin
                if (md_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = md_result;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            oldest_reg  <= '0;
            held_reg    <= '0;
            ssp_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            oldest_reg  <= oldest_next;
            held_reg    <= held_next;
            ssp_reg     <= ssp_next;
            m_valid_reg <= m_valid_next;
        end
        t_reg      <= t_next;
        p_reg      <= p_next;
        m_data_reg <= m_data_next;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
            pi_reg     <= PI_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_WINDOW:  window_reg <= cfg_data;
                CFG_PUBLISH: pi_reg     <= cfg_data[PI_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_remaining_ms = m_data_reg;

`ifndef ASSERT_OFF
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= HW'(RING_DEPTH))
        else $error("held count above ring depth");

    a_oldest_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, oldest_reg} < (AW+1)'(RING_DEPTH))
        else $error("oldest slot outside ring");

    a_pub_two: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUB_CHK) |-> (held_reg >= HW'(2)))
        else $error("estimate with fewer than two entries");

    a_idle_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !md_stat.busy)
        else $error("serial unit busy while idle");

    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        md_stat.done |-> (state_reg == ST_MULDIV))
        else $error("serial unit finished outside wait state");
`endif

endmodule

### dv/testbench.sv
module testbench;
    import swe_pkg::*;

    localparam int SETTLE_CYCLES = 300;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int RUN_LIMIT     = 6_000_000;
    localparam logic [PROD_W-1:0] ETA_SAT = {{(PROD_W-OUT_W){1'b0}}, {OUT_W{1'b1}}};

    typedef struct {
        logic              cmd;
        logic [TIME_W-1:0] t;
        logic [PROG_W-1:0] p;
    } sample_t;

    // Clock and reset
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    always #2 aclk = ~aclk;

    // DUT ports
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_cmd = CMD_ADD;
    logic [TIME_W-1:0]     s_sample_time_ms = '0;
    logic [PROG_W-1:0]     s_progress = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_W-1:0]      m_remaining_ms;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_WINDOW;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    sliding_window_eta_estimator_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_sample_time_ms (s_sample_time_ms),
        .s_progress       (s_progress),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_remaining_ms   (m_remaining_ms),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Shared testbench state
    sample_t          pending[$];
    logic [OUT_W-1:0] eta_expected[$];
    sample_t          in_flight;
    logic [OUT_W-1:0] eta_head;
    int               errors = 0;
    int unsigned      src_gap;
    int unsigned      sink_wait;
    bit               s_idle_on;
    bit               m_stall_on;
    logic [TIME_W-1:0] gen_t;
    logic [PROG_W-1:0] gen_p;

    // Predictor copy of the sample history and registers
    logic [TIME_W-1:0] hist_time[RING_DEPTH_DEF];
    logic [PROG_W-1:0] hist_prog[RING_DEPTH_DEF];
    int unsigned       hist_oldest;
    int unsigned       hist_count;
    int unsigned       since_publish;
    logic [WIN_W-1:0]  cur_window;
    logic [PI_W-1:0]   cur_interval;

    function automatic int unsigned ring_slot(input int unsigned base, input int unsigned k);
        return (base + k) % RING_DEPTH_DEF;
    endfunction

    task automatic clear_history();
        hist_oldest = 0;
        hist_count = 0;
        since_publish = 0;
    endtask

    // Apply one sample to the history and queue the estimate it publishes, if any
    task automatic estimate_step(input sample_t s);
        int unsigned       newest;
        int unsigned       slot;
        logic [63:0]       reach;
        logic [TIME_W-1:0] base_t;
        logic [PROG_W-1:0] base_p;
        logic [TIME_W-1:0] dt;
        logic [PROG_W-1:0] dp;
        logic [PROD_W-1:0] quot;
        if (s.cmd == CMD_CLEAR) begin
            clear_history();
            return;
        end
        // time or progress going backwards restarts the history
        if (hist_count > 0) begin
            newest = ring_slot(hist_oldest, hist_count - 1);
            if (s.t < hist_time[newest] || s.p < hist_prog[newest])
                clear_history();
        end
        // full ring drops its oldest entry
        if (hist_count >= RING_DEPTH_DEF) begin
            hist_oldest = ring_slot(hist_oldest, 1);
            hist_count--;
        end
        slot = ring_slot(hist_oldest, hist_count);
        hist_time[slot] = s.t;
        hist_prog[slot] = s.p;
        hist_count++;
        if (since_publish < SSP_MAX)
            since_publish++;
        // trim, keeping the newest baseline at or before the cutoff
        while (hist_count > 2) begin
            reach = 64'(hist_time[ring_slot(hist_oldest, 1)]) + 64'(cur_window);
            if (reach > 64'(s.t))
                break;
            hist_oldest = ring_slot(hist_oldest, 1);
            hist_count--;
        end
        if (since_publish < cur_interval || hist_count < 2)
            return;
        since_publish = 0;
        base_t = hist_time[hist_oldest];
        base_p = hist_prog[hist_oldest];
        if (s.p < base_p || s.t < base_t)
            return;
        dt = s.t - base_t;
        dp = s.p - base_p;
        if (dp == 0 || dt == 0 || s.p > ONE_Q24)
            return;
        quot = (PROD_W'(ONE_Q24 - s.p) * PROD_W'(dt)) / PROD_W'(dp);
        if (quot > ETA_SAT)
            eta_expected.insert(eta_expected.size(), {OUT_W{1'b1}});
        else
            eta_expected.insert(eta_expected.size(), quot[OUT_W-1:0]);
    endtask

    // Sample source: one transaction at a time from the pending queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                estimate_step(in_flight);
                src_gap = s_idle_on ? $urandom_range(7, 0) : 0;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending.size() != 0) begin
                    in_flight = pending[0];
                    pending.delete(0);
                    s_valid <= 1'b1;
                    s_cmd <= in_flight.cmd;
                    s_sample_time_ms <= in_flight.t;
                    s_progress <= in_flight.p;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result sink: checks each estimate and stalls at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (eta_expected.size() == 0) begin
                    $error("unexpected estimate: remaining_ms %0d", m_remaining_ms);
                    errors++;
                end else begin
                    eta_head = eta_expected[0];
                    eta_expected.delete(0);
                    if (m_remaining_ms !== eta_head) begin
                        $error("remaining_ms: expected %0d, actual %0d",
                               eta_head, m_remaining_ms);
                        errors++;
                    end
                end
                sink_wait = m_stall_on ? $urandom_range(7, 0) : 0;
            end else if (m_valid && sink_wait > 0) begin
                sink_wait--;
            end
            m_ready <= (sink_wait == 0);
        end
    end

    // Register write on the configuration channel
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_WINDOW)
            cur_window = val;
        else
            cur_interval = val[PI_W-1:0];
    endtask

    task automatic add_sample(input logic cmd, input logic [TIME_W-1:0] t,
                              input logic [PROG_W-1:0] p);
        sample_t s;
        s.cmd = cmd;
        s.t = t;
        s.p = p;
        pending.insert(pending.size(), s);
    endtask

    // Mostly monotonic runs with random content, plus clears and broken samples
    task automatic gen_run(input int n, input int unsigned tstep_max,
                           input int unsigned pstep_max, input int unsigned noise_pct);
        sample_t s;
        for (int i = 0; i < n; i++) begin
            s.cmd = CMD_ADD;
            if ($urandom_range(99, 0) < noise_pct) begin
                case ($urandom_range(3, 0))
                    0: begin
                        s.cmd = CMD_CLEAR;
                        s.t = TIME_W'({$urandom, $urandom});
                        s.p = PROG_W'($urandom);
                    end
                    1: begin
                        s.t = gen_t - $urandom_range(1000, 1);
                        s.p = gen_p;
                    end
                    2: begin
                        s.t = gen_t + 1;
                        s.p = gen_p - PROG_W'($urandom_range(1000, 1));
                    end
                    default: begin
                        s.t = TIME_W'({$urandom, $urandom});
                        s.p = PROG_W'($urandom);
                    end
                endcase
                if (s.cmd == CMD_ADD) begin
                    gen_t = s.t;
                    gen_p = s.p;
                end
            end else begin
                if ($urandom_range(19, 0) != 0)
                    gen_t += $urandom_range(tstep_max, 1);
                if ($urandom_range(11, 0) != 0)
                    gen_p = gen_p + PROG_W'($urandom_range(pstep_max, 1));
                // past completion: sometimes stay there, sometimes start a new run
                if (gen_p > ONE_Q24 && $urandom_range(1, 0) != 0)
                    gen_p = PROG_W'($urandom_range(ONE_Q24 / 4, 0));
                s.t = gen_t;
                s.p = gen_p;
            end
            pending.insert(pending.size(), s);
        end
    endtask

    // Wait for all samples and estimates, then let the last sample finish
    task automatic wait_idle();
        int unsigned waited;
        waited = 0;
        do @(negedge aclk); while (pending.size() != 0 || s_valid);
        while (eta_expected.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        if (eta_expected.size() != 0) begin
            $error("%0d expected estimates never arrived", eta_expected.size());
            errors += eta_expected.size();
            eta_expected.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Run limit
    initial begin
        #(RUN_LIMIT);
        $display("sliding_window_eta_estimator_top: mismatch");
        $finish;
    end

    // Phases
    initial begin
        cur_window = WINDOW_RESET;
        cur_interval = PI_RESET;
        clear_history();
        gen_t = '0;
        gen_p = '0;
        s_idle_on = 1'b1;
        m_stall_on = 1'b1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed samples
        write_reg(CFG_WINDOW, 32'd1000);
        write_reg(CFG_PUBLISH, 32'd1);
        add_sample(CMD_CLEAR, {TIME_W{1'b1}}, {PROG_W{1'b1}});
        add_sample(CMD_ADD, 48'd0, 25'd0);
        add_sample(CMD_ADD, 48'd100, 25'd0);          // no progress
        add_sample(CMD_ADD, 48'd200, 25'd4096);
        add_sample(CMD_ADD, 48'd200, 25'd8192);
        add_sample(CMD_ADD, 48'd150, 25'd9000);       // time goes back
        add_sample(CMD_ADD, 48'd2000, 25'd100);       // progress goes back
        add_sample(CMD_ADD, 48'd2000, 25'd200);       // no time elapsed
        add_sample(CMD_ADD, 48'd5000, ONE_Q24);       // complete, estimate 0
        add_sample(CMD_ADD, 48'd5001, ONE_Q24 + 25'd5); // beyond complete
        add_sample(CMD_CLEAR, 48'd0, 25'd0);
        add_sample(CMD_ADD, 48'd0, 25'd0);
        add_sample(CMD_ADD, {TIME_W{1'b1}}, 25'd1);   // saturates
        add_sample(CMD_ADD, {TIME_W{1'b1}}, {PROG_W{1'b1}});
        add_sample(CMD_CLEAR, 48'd0, 25'd0);
        add_sample(CMD_ADD, 48'h8000_0000_0000, 25'h080_0000);
        add_sample(CMD_ADD, 48'h8000_0000_0001, 25'h080_0001);
        wait_idle();

        // shortest window: trims on nearly every sample
        write_reg(CFG_WINDOW, 32'd1);
        gen_run(200, 3, ONE_Q24 / 64, 6);
        wait_idle();

        // longest window, no idling: the ring fills and wraps
        s_idle_on = 1'b0;
        m_stall_on = 1'b0;
        write_reg(CFG_WINDOW, {WIN_W{1'b1}});
        gen_run(200, 1000, ONE_Q24 / 256, 1);
        wait_idle();

        // default window, widest publish interval; upper data bits are ignored
        s_idle_on = 1'b1;
        m_stall_on = 1'b1;
        write_reg(CFG_WINDOW, 32'(WINDOW_RESET));
        write_reg(CFG_PUBLISH, {24'($urandom), SSP_MAX});
        gen_run(320, 400, ONE_Q24 / 600, 0);
        wait_idle();

        // zero publish interval: publish on every sample with history
        s_idle_on = 1'b0;
        write_reg(CFG_WINDOW, 32'd5000);
        write_reg(CFG_PUBLISH, 32'd0);
        gen_run(150, 500, ONE_Q24 / 64, 5);
        wait_idle();

        // random settings
        s_idle_on = 1'b1;
        m_stall_on = 1'b0;
        for (int k = 0; k < 4; k++) begin
            write_reg(CFG_WINDOW, $urandom_range(100000, 1));
            write_reg(CFG_PUBLISH, {24'($urandom), 8'($urandom_range(8, 1))});
            gen_run(120, cur_window / 8 + 1, ONE_Q24 / 100, 4);
            wait_idle();
            m_stall_on = ~m_stall_on;
        end

        if (errors == 0)
            $display("sliding_window_eta_estimator_top: match");
        else
            $display("sliding_window_eta_estimator_top: mismatch");
        $finish;
    end

endmodule
